// ===== rtl/lppg_pkg.sv =====
package lppg_pkg;

  // Pipeline depth and coordinate width
  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 18;
  localparam int GUARD_BITS    = 6;

  // Port field widths
  localparam int POINT_W = 18;
  localparam int RING_W  = 6;
  localparam int DIST_W  = 18;
  localparam int YAW_W   = 17;
  localparam int ANGLE_W = 16;

  localparam int IN_TDATA_W  = ((2 * POINT_W + RING_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIST_W + YAW_W + 7) / 8) * 8;

  // Coordinate bits taken from each input field
  localparam int XIN_W  = (COORD_BITS < POINT_W) ? COORD_BITS : POINT_W;
  // Working x/y: guard bits plus headroom for negation, gain and sqrt(2)
  localparam int WORK_W = COORD_BITS + GUARD_BITS + 3;
  // Working angle in 2^-16 degree
  localparam int Z_W    = 26;

  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * 65536);

  // 1/K of the CORDIC gain in Q22
  localparam int                 GAIN_W   = 22;
  localparam logic [GAIN_W-1:0]  INV_GAIN = GAIN_W'(2547003);
  localparam int                 PROD_W   = WORK_W - 1 + GAIN_W;
  localparam int                 SCALE_SH = 22 + GUARD_BITS;

  localparam int YAW_CLAMP = 46080;

  // Small queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_FIRST   = 2'd0,
    REG_RING_LAST    = 2'd1,
    REG_ANGLE_LIMIT  = 2'd2,
    REG_MAX_DISTANCE = 2'd3
  } reg_idx_t;

  typedef logic signed [WORK_W-1:0] coord_t;
  typedef logic signed [Z_W-1:0]    angle_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    angle_t z;
    logic   origin;
  } item_t;

  typedef struct packed {
    logic [RING_W-1:0]  ring_first;
    logic [RING_W-1:0]  ring_last;
    logic [ANGLE_W-1:0] angle_limit;
    logic [DIST_W-1:0]  max_distance;
  } cfg_t;

  // atan(2^-i) in 2^-16 degree, rounded
  function automatic angle_t atan_q16(input int unsigned idx);
    angle_t v;
    case (idx)
      0:       v = Z_W'(2949120);
      1:       v = Z_W'(1740967);
      2:       v = Z_W'(919879);
      3:       v = Z_W'(466945);
      4:       v = Z_W'(234379);
      5:       v = Z_W'(117304);
      6:       v = Z_W'(58666);
      7:       v = Z_W'(29335);
      8:       v = Z_W'(14668);
      9:       v = Z_W'(7334);
      10:      v = Z_W'(3667);
      11:      v = Z_W'(1833);
      12:      v = Z_W'(917);
      13:      v = Z_W'(458);
      14:      v = Z_W'(229);
      15:      v = Z_W'(115);
      16:      v = Z_W'(57);
      17:      v = Z_W'(29);
      18:      v = Z_W'(14);
      19:      v = Z_W'(7);
      20:      v = Z_W'(4);
      21:      v = Z_W'(2);
      22:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lppg_front.sv =====
module lppg_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lppg_pkg::IN_TDATA_W-1:0] in_tdata,
  input  lppg_pkg::cfg_t                  cfg,
  output logic                            push,
  output lppg_pkg::item_t                 push_item,
  input  logic                            q_full
);
  import lppg_pkg::*;

  logic              f_vld_r;
  item_t             item_r;
  item_t             item_nxt;
  logic              accept;
  logic              ring_ok;
  logic [RING_W-1:0] ring;
  logic [XIN_W-1:0]  px_raw;
  logic [XIN_W-1:0]  py_raw;
  logic              sx;
  logic              sy;
  coord_t            px_s;
  coord_t            py_s;

  assign in_tready = !f_vld_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = f_vld_r && !q_full;
  assign push_item = item_r;

  assign px_raw = in_tdata[XIN_W-1:0];
  assign py_raw = in_tdata[POINT_W +: XIN_W];
  assign ring   = in_tdata[2*POINT_W +: RING_W];

  // A wider working coordinate than the field sees the field as unsigned
  assign sx = (COORD_BITS <= POINT_W) ? px_raw[XIN_W-1] : 1'b0;
  assign sy = (COORD_BITS <= POINT_W) ? py_raw[XIN_W-1] : 1'b0;

  assign ring_ok = (ring >= cfg.ring_first) && (ring <= cfg.ring_last);

  always_comb begin
    px_s = coord_t'({{(WORK_W-XIN_W){sx}}, px_raw}) <<< GUARD_BITS;
    py_s = coord_t'({{(WORK_W-XIN_W){sy}}, py_raw}) <<< GUARD_BITS;
    item_nxt.origin = (px_s == '0) && (py_s == '0);
    // Fold the left half plane onto the right one
    if (px_s[WORK_W-1]) begin
      item_nxt.x = -px_s;
      item_nxt.y = -py_s;
      item_nxt.z = py_s[WORK_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
    end else begin
      item_nxt.x = px_s;
      item_nxt.y = py_s;
      item_nxt.z = '0;
    end
  end

  // Drop points outside the ring band right here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (accept) begin
      f_vld_r <= ring_ok;
    end else if (push) begin
      f_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/lppg_queue.sv =====
module lppg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lppg_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output lppg_pkg::item_t head,
  output logic            empty
);
  import lppg_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers wrap naturally: the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/lppg_back.sv =====
module lppg_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             empty,
  output logic                             pop,
  input  lppg_pkg::item_t                  head,
  input  lppg_pkg::cfg_t                   cfg,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lppg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lppg_pkg::*;

  localparam int YF_W = Z_W - 7;
  localparam logic signed [YF_W-1:0] YAW_HI = YF_W'(YAW_CLAMP);
  localparam logic signed [YF_W-1:0] YAW_LO = -YF_W'(YAW_CLAMP);

  logic               en;
  logic               vld_r [0:CORDIC_STAGES];
  item_t              st_r  [0:CORDIC_STAGES];
  item_t              st_nxt [1:CORDIC_STAGES];

  logic               pvld_r;
  logic [PROD_W-1:0]  prod_r;
  angle_t             pz_r;
  logic               porg_r;

  logic [PROD_W:0]    sum;
  logic [PROD_W:0]    dist_full;
  logic [DIST_W-1:0]  dist_cl;
  logic signed [Z_W:0]  z_rnd;
  logic signed [YF_W-1:0] yaw_full;
  logic signed [YF_W-1:0] yaw_cl;
  logic [YAW_W-1:0]   yaw;
  logic signed [ANGLE_W+1:0] lim_s;
  logic signed [ANGLE_W+1:0] yaw_s;
  logic               pass;

  logic               out_vld_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [YAW_W-1:0]   out_yaw_r;

  // The whole pipe advances unless a finished result is stuck
  assign en  = !out_vld_r || out_tready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= head;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    always_comb begin
      coord_t xs;
      coord_t ys;
      xs = st_r[g].x >>> g;
      ys = st_r[g].y >>> g;
      st_nxt[g+1].origin = st_r[g].origin;
      // Rotate toward the x axis
      if (!st_r[g].y[WORK_W-1]) begin
        st_nxt[g+1].x = st_r[g].x + ys;
        st_nxt[g+1].y = st_r[g].y - xs;
        st_nxt[g+1].z = st_r[g].z + atan_q16(g);
      end else begin
        st_nxt[g+1].x = st_r[g].x - ys;
        st_nxt[g+1].y = st_r[g].y + xs;
        st_nxt[g+1].z = st_r[g].z - atan_q16(g);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1] <= st_nxt[g+1];
      end
    end
  end

  // Gain correction: x is never negative after the fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else if (en) begin
      pvld_r <= vld_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(st_r[CORDIC_STAGES].x[WORK_W-2:0]) * PROD_W'(INV_GAIN);
      pz_r   <= st_r[CORDIC_STAGES].z;
      porg_r <= st_r[CORDIC_STAGES].origin;
    end
  end

  // Round half up, saturate, then clamp yaw
  always_comb begin
    sum       = {1'b0, prod_r} + ((PROD_W+1)'(1) << (SCALE_SH - 1));
    dist_full = sum >> SCALE_SH;
    if (dist_full > (PROD_W+1)'({DIST_W{1'b1}})) begin
      dist_cl = '1;
    end else begin
      dist_cl = dist_full[DIST_W-1:0];
    end

    z_rnd    = {pz_r[Z_W-1], pz_r} + (Z_W+1)'(128);
    yaw_full = z_rnd[Z_W:8];
    if (yaw_full > YAW_HI) begin
      yaw_cl = YAW_HI;
    end else if (yaw_full < YAW_LO) begin
      yaw_cl = YAW_LO;
    end else begin
      yaw_cl = yaw_full;
    end
    yaw = yaw_cl[YAW_W-1:0];

    // Origin point has no direction
    if (porg_r) begin
      dist_cl = '0;
      yaw     = '0;
    end

    lim_s = $signed({2'b00, cfg.angle_limit});
    yaw_s = $signed({yaw[YAW_W-1], yaw});
    pass  = (dist_cl <= cfg.max_distance) && (yaw_s <= lim_s) && (yaw_s >= -lim_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= pvld_r && pass;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r <= dist_cl;
      out_yaw_r  <= yaw;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-DIST_W-YAW_W){1'b0}}, out_yaw_r, out_dist_r};

endmodule

// ===== rtl/lidar_point_polar_gate.sv =====
// A passing point reaches out_tvalid through the input register, queue, pipe entry
// register, CORDIC_STAGES rotation stages, gain multiply register and output register.
// Throughput: one point per cycle through the CORDIC pipe unless the output stalls.
// A held output register (out_tready low) stalls the back pipe; the four-entry queue
// and the input register keep taking points until it fills. Reset (rst_n low,
// synchronous) empties the pipe and queue and loads the register defaults.
module lidar_point_polar_gate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // point_x[17:0], point_y[35:18], ring_number[41:36], zero pad
  input  logic [lppg_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // obstacle_distance[17:0], obstacle_yaw[34:18], zero pad
  output logic [lppg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [lppg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lppg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lppg_pkg::*;

  cfg_t  cfg_r;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  item_t head;
  logic  empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_first   <= RING_W'(13);
      cfg_r.ring_last    <= RING_W'(15);
      cfg_r.angle_limit  <= ANGLE_W'(15360);
      cfg_r.max_distance <= DIST_W'(819);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_RING_FIRST:   cfg_r.ring_first   <= cfg_wdata[RING_W-1:0];
        REG_RING_LAST:    cfg_r.ring_last    <= cfg_wdata[RING_W-1:0];
        REG_ANGLE_LIMIT:  cfg_r.angle_limit  <= cfg_wdata[ANGLE_W-1:0];
        REG_MAX_DISTANCE: cfg_r.max_distance <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  lppg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  lppg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  lppg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .head       (head),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lppg_pkg::*;

  localparam int LATENCY     = CORDIC_STAGES + 4;
  localparam int STALL_LIMIT = 2000;
  localparam longint INV_K_Q22 = 2547003;
  localparam longint DIST_SAT  = 262143;
  localparam longint YAW_SAT   = 46080;

  // atan(2^-i) in 2^-16 degree
  localparam longint ARCTAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic [DIST_W-1:0]       distance;
    logic signed [YAW_W-1:0] yaw;
  } obstacle_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // point_x[17:0], point_y[35:18], ring_number[41:36], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // obstacle_distance[17:0], obstacle_yaw[34:18], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Mirror of the gate registers
  logic [RING_W-1:0]  cfg_ring_lo;
  logic [RING_W-1:0]  cfg_ring_hi;
  logic [ANGLE_W-1:0] cfg_angle;
  logic [DIST_W-1:0]  cfg_range;

  obstacle_t pending_obstacles[$];
  obstacle_t want_obstacle;
  obstacle_t got_obstacle;
  obstacle_t new_obstacle;

  bit idle_on = 1'b1;
  int errors = 0;
  int points_sent = 0;
  int obstacles_seen = 0;
  int settings_used = 0;
  int stall_cycles = 0;

  lidar_point_polar_gate u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Polar conversion and gating of one point; returns 1 when an obstacle is reported
  function automatic bit gate_point(input logic signed [POINT_W-1:0] px,
                                    input logic signed [POINT_W-1:0] py,
                                    input logic [RING_W-1:0] ring,
                                    output obstacle_t res);
    longint x, y, z, xs, ys, dist_v, yaw;
    dist_v = 0;
    yaw = 0;
    res.distance = '0;
    res.yaw = '0;
    if (px != 0 || py != 0) begin
      x = longint'(px) * (longint'(1) << GUARD_BITS);
      y = longint'(py) * (longint'(1) << GUARD_BITS);
      z = 0;
      // fold the left half plane onto the right one
      if (x < 0) begin
        z = (y >= 0) ? 180 * 65536 : -180 * 65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_STEP[i];
        end
      end
      dist_v = (x * INV_K_Q22 + (longint'(1) << (21 + GUARD_BITS))) >>> (22 + GUARD_BITS);
      if (dist_v < 0) dist_v = 0;
      if (dist_v > DIST_SAT) dist_v = DIST_SAT;
      yaw = (z + 128) >>> 8;
      if (yaw > YAW_SAT) yaw = YAW_SAT;
      if (yaw < -YAW_SAT) yaw = -YAW_SAT;
    end
    if (ring < cfg_ring_lo || ring > cfg_ring_hi) return 1'b0;
    if (yaw > longint'(cfg_angle) || yaw < -longint'(cfg_angle)) return 1'b0;
    if (dist_v > longint'(cfg_range)) return 1'b0;
    res.distance = dist_v[DIST_W-1:0];
    res.yaw = yaw[YAW_W-1:0];
    return 1'b1;
  endfunction

  // Track register writes, predict accepted points and check reported obstacles
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ring_lo <= 6'd13;
      cfg_ring_hi <= 6'd15;
      cfg_angle <= 16'd15360;
      cfg_range <= 18'd819;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RING_FIRST:   cfg_ring_lo <= cfg_wdata[RING_W-1:0];
          REG_RING_LAST:    cfg_ring_hi <= cfg_wdata[RING_W-1:0];
          REG_ANGLE_LIMIT:  cfg_angle <= cfg_wdata[ANGLE_W-1:0];
          REG_MAX_DISTANCE: cfg_range <= cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        points_sent++;
        if (gate_point(in_tdata[POINT_W-1:0], in_tdata[2*POINT_W-1:POINT_W],
                       in_tdata[2*POINT_W+RING_W-1:2*POINT_W], new_obstacle))
          pending_obstacles.push_back(new_obstacle);
      end
      if (out_tvalid && out_tready) begin
        obstacles_seen++;
        got_obstacle.distance = out_tdata[DIST_W-1:0];
        got_obstacle.yaw = out_tdata[DIST_W+YAW_W-1:DIST_W];
        if (pending_obstacles.size() == 0) begin
          $display("%0t: unexpected obstacle, distance %0d yaw %0d", $time,
                   got_obstacle.distance, got_obstacle.yaw);
          errors++;
        end else begin
          want_obstacle = pending_obstacles.pop_front();
          if (got_obstacle.distance !== want_obstacle.distance) begin
            $display("%0t: obstacle_distance expected %0d, got %0d", $time,
                     want_obstacle.distance, got_obstacle.distance);
            errors++;
          end
          if (got_obstacle.yaw !== want_obstacle.yaw) begin
            $display("%0t: obstacle_yaw expected %0d, got %0d", $time,
                     want_obstacle.yaw, got_obstacle.yaw);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  always @(negedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // Called and returns at a falling edge; valid stays high after the item is taken
  task automatic send_point(input logic signed [POINT_W-1:0] px,
                            input logic signed [POINT_W-1:0] py,
                            input logic [RING_W-1:0] ring);
    while (idle_on && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({ring, py, px});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold the input until every pending obstacle is out; optionally let the pipe settle
  task automatic drain_pipe(input bit settle);
    in_tvalid <= 1'b0;
    while (pending_obstacles.size() != 0) @(negedge clk);
    if (settle) repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] ring_lo,
                            input logic [CFG_DATA_W-1:0] ring_hi,
                            input logic [CFG_DATA_W-1:0] angle,
                            input logic [CFG_DATA_W-1:0] range);
    drain_pipe(1'b1);
    cfg_we <= 1'b1;
    cfg_index <= REG_RING_FIRST;
    cfg_wdata <= ring_lo;
    @(negedge clk);
    cfg_index <= REG_RING_LAST;
    cfg_wdata <= ring_hi;
    @(negedge clk);
    cfg_index <= REG_ANGLE_LIMIT;
    cfg_wdata <= angle;
    @(negedge clk);
    cfg_index <= REG_MAX_DISTANCE;
    cfg_wdata <= range;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic test_reset_config();
    settings_used++;
    send_point(0, 0, 13);
    send_point(500, 300, 14);
    send_point(500, 300, 12);
    send_point(500, 300, 16);
    send_point(819, 0, 15);
    send_point(820, 0, 15);
    send_point(300, 600, 13);
    send_point(400, -400, 13);
  endtask

  // Fully open gate; the ring and angle writes carry bits above their register widths
  task automatic test_coordinate_extremes();
    set_config(18'h3FFC0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_point(131071, 131071, 63);
    send_point(-131072, -131072, 0);
    send_point(-131072, 0, 32);
    send_point(-1, 0, 1);
    send_point(0, 131071, 2);
    send_point(0, -131072, 3);
    send_point(131071, -131072, 62);
    send_point(-131072, 131071, 5);
    send_point(1, 0, 7);
  endtask

  task automatic test_empty_ring_band();
    set_config(40, 20, 46080, 185364);
    send_point(0, 0, 30);
    send_point(100, 100, 40);
    send_point(100, 100, 20);
  endtask

  task automatic test_closed_gates();
    set_config(5, 5, 0, 0);
    send_point(0, 0, 5);
    send_point(1, 0, 5);
    send_point(0, 0, 6);
  endtask

  function automatic logic signed [POINT_W-1:0] pick_coord(input int lim);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return POINT_W'($urandom());
    if (sel < 85) return POINT_W'(int'($urandom_range(2 * lim)) - lim);
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return 131071;
      default: return -131072;
    endcase
  endfunction

  task automatic test_random_points();
    int lim, first;
    logic [RING_W-1:0] ring;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        set_config(0, 63, 65535, 262143);
        idle_on = 1'b0;
      end else begin
        first = $urandom_range(63);
        set_config(first,
                   ($urandom_range(99) < 85) ? $urandom_range(63, first) : $urandom_range(63),
                   ($urandom_range(99) < 90) ? $urandom_range(46080) : 65535,
                   $urandom_range(185364));
        idle_on = 1'b1;
      end
      lim = (cfg_range > 131071) ? 131071 : int'(cfg_range);
      for (int n = 0; n < 330; n++) begin
        if (phase == 3 && n == 165) drain_pipe(1'b0);
        if (cfg_ring_lo <= cfg_ring_hi && $urandom_range(99) < 70)
          ring = $urandom_range(cfg_ring_hi, cfg_ring_lo);
        else
          ring = $urandom_range(63);
        send_point(pick_coord(lim), pick_coord(lim), ring);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_config();
    test_coordinate_extremes();
    test_empty_ring_band();
    test_closed_gates();
    test_random_points();
    drain_pipe(1'b1);
    $display("Covered %0d points under %0d gate settings, %0d obstacles compared",
             points_sent, settings_used, obstacles_seen);
    $display("including origin, axis, band and saturation corners; %0d mismatches", errors);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
